[rtl/rfp_pkg.sv]
// Shared types and constants for the row filter and projection block.
// Used by every module under rtl except rfp_ram; depends on nothing else.

package rfp_pkg;

    // Configuration register indexes on the write port.
    localparam logic [2:0] REG_FILTER_ENABLE  = 3'd0;
    localparam logic [2:0] REG_FILTER_COLUMN  = 3'd1;
    localparam logic [2:0] REG_FILTER_OP      = 3'd2;
    localparam logic [2:0] REG_FILTER_VALUE   = 3'd3;
    localparam logic [2:0] REG_PROJ_COUNT     = 3'd4;
    localparam logic [2:0] REG_PROJ_COLUMNS   = 3'd5;

    // Filter comparison codes; codes 6 and 7 never match.
    localparam logic [2:0] OP_GT = 3'd0;
    localparam logic [2:0] OP_GE = 3'd1;
    localparam logic [2:0] OP_LT = 3'd2;
    localparam logic [2:0] OP_LE = 3'd3;
    localparam logic [2:0] OP_EQ = 3'd4;
    localparam logic [2:0] OP_NE = 3'd5;

    // Result status codes.
    localparam logic [1:0] ST_DATA      = 2'd0;
    localparam logic [1:0] ST_FILT_MISS = 2'd1;
    localparam logic [1:0] ST_PROJ_MISS = 2'd2;

    // Slots held by the projection column register.
    localparam int PROJ_SLOTS = 8;

    // Length of a row or of a projection, wide enough for 64 columns.
    typedef logic [6:0] len_t;

    typedef enum logic [1:0] {
        KIND_ERR,
        KIND_WHOLE,
        KIND_PROJ
    } kind_t;

    typedef enum logic {
        BE_IDLE,
        BE_RUN
    } back_state_t;

    typedef struct packed {
        logic        filter_enable;
        logic [3:0]  filter_column;
        logic [2:0]  filter_op;
        logic [63:0] filter_value;
        logic [3:0]  projection_count;
        logic [31:0] proj_list;
    } cfg_t;

    // Work handed from the front end to the back end for one finished row.
    typedef struct packed {
        kind_t       kind;
        logic        bank;
        len_t        len;
        logic [31:0] row;
        logic [1:0]  status;
        logic [3:0]  bad;
    } desc_t;

    // The back end hands a row buffer bank back to the front end.
    typedef struct packed {
        logic valid;
        logic bank;
    } bank_free_t;

    typedef struct packed {
        logic [63:0] value;
        logic [1:0]  status;
        logic [31:0] row;
        logic [3:0]  bad;
        logic        last;
    } result_t;

endpackage

[rtl/rfp_ram.sv]
// Generic single-write, single-read RAM with a registered read port.
// Standalone; no package needed.

module rfp_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 32
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

[rtl/rfp_queue.sv]
// Two-entry queue of row descriptors between the front and back ends.
// Depends on rfp_pkg for desc_t.

module rfp_queue (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  rfp_pkg::desc_t push_data,
    output logic           full,
    input  logic           pop,
    output logic           valid,
    output rfp_pkg::desc_t pop_data
);

    rfp_pkg::desc_t entry_reg [2];
    logic           rd_reg;
    logic           rd_next;
    logic           wr_reg;
    logic           wr_next;
    logic [1:0]     count_reg;
    logic [1:0]     count_next;

    assign full     = (count_reg == 2'd2);
    assign valid    = (count_reg != 2'd0);
    assign pop_data = entry_reg[rd_reg];

    always_comb
    begin
        rd_next    = pop ? ~rd_reg : rd_reg;
        wr_next    = push ? ~wr_reg : wr_reg;
        count_next = count_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_reg    <= 1'b0;
            wr_reg    <= 1'b0;
            count_reg <= 2'd0;
        end
        else
        begin
            rd_reg    <= rd_next;
            wr_reg    <= wr_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_reg] <= push_data;
        end
    end

`ifndef SYNTH
    // The back end only takes a descriptor that is actually there.
    a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> (count_reg != 2'd0))
        else $error("descriptor queue popped while empty");
`endif

endmodule

[rtl/rfp_front.sv]
// Front end: takes column items, writes them into the row buffer, captures the
// filter column and classifies each finished row. Depends on rfp_pkg.

module rfp_front #(
    parameter int MAX_COLUMNS    = 16,
    parameter int MAX_PROJECTION = 8
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  rfp_pkg::cfg_t                   cfg,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [63:0]                     s_tdata,
    input  logic                            s_tlast,
    output logic                            ram_we,
    output logic [$clog2(MAX_COLUMNS):0]    ram_waddr,
    output logic [63:0]                     ram_wdata,
    output logic                            q_push,
    output rfp_pkg::desc_t                  q_data,
    input  logic                            q_full,
    input  rfp_pkg::bank_free_t             bank_free
);

    localparam int IW   = $clog2(MAX_COLUMNS);
    localparam int CW   = $clog2(MAX_COLUMNS + 1);
    localparam int CMPW = (CW > 4) ? CW : 4;
    localparam int PLIM = (MAX_PROJECTION < rfp_pkg::PROJ_SLOTS) ?
                          MAX_PROJECTION : rfp_pkg::PROJ_SLOTS;

    logic [CW-1:0] cnt_reg;
    logic [CW-1:0] cnt_next;
    logic          wbank_reg;
    logic          wbank_next;
    logic [1:0]    busy_reg;
    logic [1:0]    busy_next;
    logic [31:0]   row_reg;
    logic [31:0]   row_next;
    logic [63:0]   cap_reg;

    logic          accept;
    logic          store;
    logic [CW-1:0] len;
    logic          cap_hit;
    logic [63:0]   fval;
    logic          cmp_pass;
    logic [3:0]    pcount;
    logic          proj_miss;
    logic [3:0]    proj_bad;
    logic          filt_miss;
    logic          take_bank;

    // A new item is taken only when the bank being filled is free and a
    // finished row would find room in the queue.
    assign s_tready = !busy_reg[wbank_reg] && !q_full;
    assign accept   = s_tvalid && s_tready;
    assign store    = accept && (cnt_reg < CW'(MAX_COLUMNS));
    assign len      = store ? CW'(cnt_reg + 1'b1) : cnt_reg;

    assign cap_hit  = store && (CMPW'(cnt_reg) == CMPW'(cfg.filter_column));
    assign fval     = cap_hit ? s_tdata : cap_reg;

    assign ram_we    = store;
    assign ram_waddr = {wbank_reg, IW'(cnt_reg)};
    assign ram_wdata = s_tdata;

    assign pcount    = (cfg.projection_count > 4'(PLIM)) ? 4'(PLIM) :
                       cfg.projection_count;
    assign filt_miss = (CMPW'(cfg.filter_column) >= CMPW'(len));

    always_comb
    begin
        cmp_pass = 1'b0;
        case (cfg.filter_op)
            rfp_pkg::OP_GT: cmp_pass = $signed(fval) >  $signed(cfg.filter_value);
            rfp_pkg::OP_GE: cmp_pass = $signed(fval) >= $signed(cfg.filter_value);
            rfp_pkg::OP_LT: cmp_pass = $signed(fval) <  $signed(cfg.filter_value);
            rfp_pkg::OP_LE: cmp_pass = $signed(fval) <= $signed(cfg.filter_value);
            rfp_pkg::OP_EQ: cmp_pass = (fval == cfg.filter_value);
            rfp_pkg::OP_NE: cmp_pass = (fval != cfg.filter_value);
            default:        cmp_pass = 1'b0;
        endcase
    end

    // The first projected entry that lies past the row's end is the one
    // reported; walking from the top lets the lowest entry win.
    always_comb
    begin
        proj_miss = 1'b0;
        proj_bad  = 4'd0;
        for (int k = rfp_pkg::PROJ_SLOTS - 1; k >= 0; k--)
        begin
            if ((4'(k) < pcount) &&
                (CMPW'(cfg.proj_list[4*k +: 4]) >= CMPW'(len)))
            begin
                proj_miss = 1'b1;
                proj_bad  = cfg.proj_list[4*k +: 4];
            end
        end
    end

    always_comb
    begin
        q_push        = 1'b0;
        take_bank     = 1'b0;
        q_data.kind   = rfp_pkg::KIND_WHOLE;
        q_data.bank   = wbank_reg;
        q_data.len    = rfp_pkg::len_t'(len);
        q_data.row    = row_reg;
        q_data.status = rfp_pkg::ST_DATA;
        q_data.bad    = 4'd0;
        if (accept && s_tlast)
        begin
            if (cfg.filter_enable && filt_miss)
            begin
                q_push        = 1'b1;
                q_data.kind   = rfp_pkg::KIND_ERR;
                q_data.len    = rfp_pkg::len_t'(1);
                q_data.status = rfp_pkg::ST_FILT_MISS;
                q_data.bad    = cfg.filter_column;
            end
            else if (cfg.filter_enable && !cmp_pass)
            begin
                q_push = 1'b0;
            end
            else if (pcount == 4'd0)
            begin
                q_push    = 1'b1;
                take_bank = 1'b1;
            end
            else if (proj_miss)
            begin
                q_push        = 1'b1;
                q_data.kind   = rfp_pkg::KIND_ERR;
                q_data.len    = rfp_pkg::len_t'(1);
                q_data.status = rfp_pkg::ST_PROJ_MISS;
                q_data.bad    = proj_bad;
            end
            else
            begin
                q_push      = 1'b1;
                take_bank   = 1'b1;
                q_data.kind = rfp_pkg::KIND_PROJ;
                q_data.len  = rfp_pkg::len_t'(pcount);
            end
        end
    end

    always_comb
    begin
        cnt_next   = cnt_reg;
        row_next   = row_reg;
        wbank_next = take_bank ? ~wbank_reg : wbank_reg;
        busy_next  = busy_reg;
        if (accept)
        begin
            cnt_next = s_tlast ? '0 : len;
            if (s_tlast)
            begin
                row_next = row_reg + 32'd1;
            end
        end
        if (bank_free.valid)
        begin
            busy_next[bank_free.bank] = 1'b0;
        end
        if (take_bank)
        begin
            busy_next[wbank_reg] = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg   <= '0;
            row_reg   <= 32'd0;
            wbank_reg <= 1'b0;
            busy_reg  <= 2'b00;
        end
        else
        begin
            cnt_reg   <= cnt_next;
            row_reg   <= row_next;
            wbank_reg <= wbank_next;
            busy_reg  <= busy_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cap_hit)
        begin
            cap_reg <= s_tdata;
        end
    end

`ifndef SYNTH
    // A column never lands in a bank that the back end may still be reading.
    a_write_free_bank: assert property (@(posedge clk) disable iff (!rst_n)
        ram_we |-> !busy_reg[wbank_reg])
        else $error("row buffer write into a busy bank");

    // The back end only returns a bank that was handed to it.
    a_free_busy_bank: assert property (@(posedge clk) disable iff (!rst_n)
        bank_free.valid |-> busy_reg[bank_free.bank])
        else $error("bank released that was not in use");
`endif

endmodule

[rtl/rfp_back.sv]
// Back end: runs each row descriptor, reading the row buffer once per result,
// and queues results in a two-entry output buffer. Depends on rfp_pkg.

module rfp_back #(
    parameter int MAX_COLUMNS = 16
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  rfp_pkg::cfg_t                 cfg,
    input  logic                          q_valid,
    input  rfp_pkg::desc_t                q_data,
    output logic                          q_pop,
    output logic [$clog2(MAX_COLUMNS):0]  ram_raddr,
    input  logic [63:0]                   ram_rdata,
    output rfp_pkg::bank_free_t           bank_free,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [103:0]                  m_tdata,
    output logic [1:0]                    m_tuser,
    output logic                          m_tlast
);

    localparam int IW   = $clog2(MAX_COLUMNS);
    localparam int NMAX = (MAX_COLUMNS > rfp_pkg::PROJ_SLOTS) ?
                          MAX_COLUMNS : rfp_pkg::PROJ_SLOTS;
    localparam int KW   = $clog2(NMAX);

    rfp_pkg::back_state_t state_reg;
    rfp_pkg::back_state_t state_next;
    rfp_pkg::desc_t       act_reg;
    logic [KW-1:0]        k_reg;
    logic [KW-1:0]        k_next;

    // Read stage, aligned with the RAM's registered output.
    logic                 pv_reg;
    logic                 pm_ram_reg;
    logic [1:0]           pm_status_reg;
    logic [31:0]          pm_row_reg;
    logic [3:0]           pm_bad_reg;
    logic                 pm_last_reg;

    // Output buffer.
    rfp_pkg::result_t     fifo_reg [2];
    logic                 rd_reg;
    logic                 wr_reg;
    logic [1:0]           fcount_reg;
    logic [1:0]           fcount_next;

    logic                 out_pop;
    logic                 credit;
    logic                 issue;
    logic                 k_last;
    logic [3:0]           pcol;
    rfp_pkg::result_t     res;
    rfp_pkg::result_t     head;

    assign out_pop = m_tvalid && m_tready;
    // A read may start when its data is sure of a place in the output buffer.
    assign credit  = (({1'b0, fcount_reg} + {2'b00, pv_reg}) < 3'd2) || out_pop;
    assign k_last  = (k_reg == KW'(act_reg.len - rfp_pkg::len_t'(1)));
    assign pcol    = cfg.proj_list[{k_reg[2:0], 2'b00} +: 4];

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            rfp_pkg::BE_IDLE:
            begin
                if (q_valid)
                begin
                    state_next = rfp_pkg::BE_RUN;
                end
            end
            rfp_pkg::BE_RUN:
            begin
                if (credit && k_last)
                begin
                    state_next = rfp_pkg::BE_IDLE;
                end
            end
            default: state_next = rfp_pkg::BE_IDLE;
        endcase
    end

    always_comb
    begin
        q_pop = 1'b0;
        issue = 1'b0;
        case (state_reg)
            rfp_pkg::BE_IDLE: q_pop = q_valid;
            rfp_pkg::BE_RUN:  issue = credit;
            default:
            begin
                q_pop = 1'b0;
                issue = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        k_next = k_reg;
        if (q_pop)
        begin
            k_next = '0;
        end
        else if (issue)
        begin
            k_next = KW'(k_reg + 1'b1);
        end
    end

    assign ram_raddr = {act_reg.bank,
                        (act_reg.kind == rfp_pkg::KIND_PROJ) ? IW'(pcol) : IW'(k_reg)};

    assign bank_free.valid = issue && k_last && (act_reg.kind != rfp_pkg::KIND_ERR);
    assign bank_free.bank  = act_reg.bank;

    always_comb
    begin
        res.value  = pm_ram_reg ? ram_rdata : 64'd0;
        res.status = pm_status_reg;
        res.row    = pm_row_reg;
        res.bad    = pm_bad_reg;
        res.last   = pm_last_reg;
    end

    assign fcount_next = fcount_reg + {1'b0, pv_reg} - {1'b0, out_pop};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= rfp_pkg::BE_IDLE;
            k_reg      <= '0;
            pv_reg     <= 1'b0;
            rd_reg     <= 1'b0;
            wr_reg     <= 1'b0;
            fcount_reg <= 2'd0;
        end
        else
        begin
            state_reg  <= state_next;
            k_reg      <= k_next;
            pv_reg     <= issue;
            rd_reg     <= out_pop ? ~rd_reg : rd_reg;
            wr_reg     <= pv_reg ? ~wr_reg : wr_reg;
            fcount_reg <= fcount_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            act_reg <= q_data;
        end
        if (issue)
        begin
            pm_ram_reg    <= (act_reg.kind != rfp_pkg::KIND_ERR);
            pm_status_reg <= act_reg.status;
            pm_row_reg    <= act_reg.row;
            pm_bad_reg    <= act_reg.bad;
            pm_last_reg   <= k_last;
        end
        if (pv_reg)
        begin
            fifo_reg[wr_reg] <= res;
        end
    end

    assign head     = fifo_reg[rd_reg];
    assign m_tvalid = (fcount_reg != 2'd0);
    assign m_tdata  = {4'd0, head.bad, head.row, head.value};
    assign m_tuser  = head.status;
    assign m_tlast  = head.last;

`ifndef SYNTH
    // Read data coming back from the RAM always finds a free buffer slot.
    a_room_for_read: assert property (@(posedge clk) disable iff (!rst_n)
        pv_reg |-> ((fcount_reg != 2'd2) || out_pop))
        else $error("output buffer overrun");

    // Handing back a bank finishes the row in progress.
    a_free_ends_row: assert property (@(posedge clk) disable iff (!rst_n)
        bank_free.valid |=> (state_reg == rfp_pkg::BE_IDLE))
        else $error("bank released before the row was done");
`endif

endmodule

[rtl/row_filter_projection_top.sv]
// Top level of the row filter and projection block: configuration registers,
// row buffer RAM, front end, descriptor queue and back end.
// Depends on rfp_pkg, rfp_ram, rfp_front, rfp_queue and rfp_back.
//
//  channel   | direction | handshake          | payload
//  ----------+-----------+--------------------+------------------------------------
//  s_*       | in        | s_tvalid/s_tready  | tdata column_value, tlast row_end
//  m_*       | out       | m_tvalid/m_tready  | tdata value,row,bad; tuser status;
//            |           |                    | tlast last_of_row
//  cfg_*     | in        | cfg_wen            | cfg_addr register, cfg_wdata value
//
// The front end takes one column item per cycle while the row buffer bank it
// fills is free and the descriptor queue has room; two banks let one row fill
// while the previous one is read. The back end gives one result per cycle,
// one RAM read each, while its output buffer has room, and takes each row's
// descriptor in its idle state before that row's first read; each read is
// registered in the read stage and then in the output buffer before it is offered.
// Reset is asynchronous and active low; no clearing pass is needed.
// Either side may stall: the descriptor queue and a two-entry output buffer
// let the input keep flowing while results wait to be taken.

module row_filter_projection_top #(
    parameter int MAX_COLUMNS    = 16,
    parameter int MAX_PROJECTION = 8
) (
    input  logic         clk,
    input  logic         rst_n,
    // column_value [63:0]
    input  logic [63:0]  s_tdata,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic         s_tlast,
    // out_value [63:0], row_number [95:64], bad_column [99:96], zero pad [103:100]
    output logic [103:0] m_tdata,
    // status [1:0]
    output logic [1:0]   m_tuser,
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic         m_tlast,
    input  logic         cfg_wen,
    input  logic [2:0]   cfg_addr,
    input  logic [63:0]  cfg_wdata
);

    localparam int IW        = $clog2(MAX_COLUMNS);
    localparam int RAM_DEPTH = 2 * (1 << IW);

    rfp_pkg::cfg_t       cfg_reg;
    rfp_pkg::cfg_t       cfg_next;

    logic                ram_we;
    logic [IW:0]         ram_waddr;
    logic [63:0]         ram_wdata;
    logic [IW:0]         ram_raddr;
    logic [63:0]         ram_rdata;

    logic                q_push;
    rfp_pkg::desc_t      q_push_data;
    logic                q_full;
    logic                q_pop;
    logic                q_valid;
    rfp_pkg::desc_t      q_pop_data;
    rfp_pkg::bank_free_t bank_free;

    // Configuration writes; an index past the last register is ignored.
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_wen)
        begin
            case (cfg_addr)
                rfp_pkg::REG_FILTER_ENABLE: cfg_next.filter_enable      = cfg_wdata[0];
                rfp_pkg::REG_FILTER_COLUMN: cfg_next.filter_column      = cfg_wdata[3:0];
                rfp_pkg::REG_FILTER_OP:     cfg_next.filter_op          = cfg_wdata[2:0];
                rfp_pkg::REG_FILTER_VALUE:  cfg_next.filter_value       = cfg_wdata;
                rfp_pkg::REG_PROJ_COUNT:    cfg_next.projection_count   = cfg_wdata[3:0];
                rfp_pkg::REG_PROJ_COLUMNS:  cfg_next.proj_list          = cfg_wdata[31:0];
                default:                    cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.filter_enable      <= 1'b0;
            cfg_reg.filter_column      <= 4'd0;
            cfg_reg.filter_op          <= rfp_pkg::OP_EQ;
            cfg_reg.filter_value       <= 64'd0;
            cfg_reg.projection_count   <= 4'd0;
            cfg_reg.proj_list          <= 32'd0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    // Row buffer: two banks of MAX_COLUMNS entries rounded up to a power of two, bank in the top address bit.
    rfp_ram #(
        .WIDTH (64),
        .DEPTH (RAM_DEPTH)
    ) u_row_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    rfp_front #(
        .MAX_COLUMNS    (MAX_COLUMNS),
        .MAX_PROJECTION (MAX_PROJECTION)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .ram_we    (ram_we),
        .ram_waddr (ram_waddr),
        .ram_wdata (ram_wdata),
        .q_push    (q_push),
        .q_data    (q_push_data),
        .q_full    (q_full),
        .bank_free (bank_free)
    );

    rfp_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_data (q_push_data),
        .full      (q_full),
        .pop       (q_pop),
        .valid     (q_valid),
        .pop_data  (q_pop_data)
    );

    rfp_back #(
        .MAX_COLUMNS (MAX_COLUMNS)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .q_valid   (q_valid),
        .q_data    (q_pop_data),
        .q_pop     (q_pop),
        .ram_raddr (ram_raddr),
        .ram_rdata (ram_rdata),
        .bank_free (bank_free),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

endmodule
